[rtl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the bencode syntax checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int POS_BITS  = 16;
    localparam int ACC_W     = POS_BITS + 4;  // length accumulate, before saturation
    localparam logic [POS_BITS-1:0] POS_LIMIT = {POS_BITS{1'b1}};

    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_MALFORMED  = 2'd2,
        ST_LIMIT      = 2'd3
    } t_status;

    // container kinds held in the stack
    typedef enum logic [1:0] {
        KIND_LIST = 2'd0,
        KIND_DKEY = 2'd1,
        KIND_DVAL = 2'd2
    } t_kind;

    typedef enum logic [6:0] {
        PH_EXPECT     = 7'b0000001,
        PH_INT_START  = 7'b0000010,
        PH_INT_NEG    = 7'b0000100,
        PH_INT_ZERO   = 7'b0001000,
        PH_INT_DIGITS = 7'b0010000,
        PH_STR_LEN    = 7'b0100000,
        PH_STR_BODY   = 7'b1000000
    } t_phase;

    // command from the parser to the stack memory
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              top_we;
        t_kind             top_val;
    } t_stack_cmd;

    typedef struct packed {
        logic                valid;
        t_status             status;
        logic [POS_BITS-1:0] position;
    } t_result;

    typedef struct packed {
        logic [DEPTH_W-1:0] level;
        logic               given;
    } t_ctrl_stat;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // a finished value flips a dictionary between key and value
    function automatic t_kind flip_kind(input t_kind k);
        t_kind r;
        case (k)
            KIND_DKEY: r = KIND_DVAL;
            KIND_DVAL: r = KIND_DKEY;
            default:   r = k;
        endcase
        return r;
    endfunction

endpackage

[rtl/bsc_stack.sv]
// ----------------------------------------------------------------------------
// bsc_stack
// Nesting stack: top entry in a register, lower entries in a synchronous RAM.
// The entry just below the top is read every cycle, write-to-read bypassed.
// ----------------------------------------------------------------------------
module bsc_stack (
    input  logic                i_clk,
    input  bsc_pkg::t_stack_cmd i_cmd,
    output bsc_pkg::t_kind      o_top,
    output bsc_pkg::t_kind      o_below
);

    bsc_pkg::t_kind r_mem [bsc_pkg::MAX_DEPTH];
    bsc_pkg::t_kind r_top;
    bsc_pkg::t_kind r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= r_top;
        end
        // bypass: pushed entry read back on the next cycle
        if (i_cmd.wr_en && (i_cmd.wr_addr == i_cmd.rd_addr)) begin
            r_rd <= r_top;
        end else begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
        if (i_cmd.top_we) begin
            r_top <= i_cmd.top_val;
        end
    end

    assign o_top   = r_top;
    assign o_below = r_rd;

endmodule

[rtl/bsc_ctrl.sv]
// ----------------------------------------------------------------------------
// bsc_ctrl
// Per-byte parse control: phase, level, string length, byte count.
// Issues push/pop/modify commands to the stack and forms the result.
// ----------------------------------------------------------------------------
module bsc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  bsc_pkg::t_kind       i_top,
    input  bsc_pkg::t_kind       i_below,
    output bsc_pkg::t_stack_cmd  o_cmd,
    output bsc_pkg::t_result     o_res,
    output bsc_pkg::t_ctrl_stat  o_stat
);

    bsc_pkg::t_phase                 r_phase, n_phase, p_phase;
    logic [bsc_pkg::DEPTH_W-1:0]     r_level, n_level, p_level;
    logic [bsc_pkg::POS_BITS-1:0]    r_rem, n_rem, p_rem;
    logic [bsc_pkg::POS_BITS-1:0]    r_count, n_count;
    logic                            r_given, n_given;

    logic                            v_none, v_done, v_push, v_pop;
    bsc_pkg::t_status                v_st;
    bsc_pkg::t_kind                  v_kind, v_base;
    logic                            v_top_we;
    bsc_pkg::t_kind                  v_top_val;
    logic [bsc_pkg::ACC_W-1:0]       v_acc;
    logic [bsc_pkg::POS_BITS-1:0]    v_dec;
    logic                            v_apply;
    logic [bsc_pkg::DEPTH_W-1:0]     v_rd;

    always_comb begin
        p_phase   = r_phase;
        p_level   = r_level;
        p_rem     = r_rem;
        v_none    = 1'b1;
        v_st      = bsc_pkg::ST_VALID;
        v_done    = 1'b0;
        v_push    = 1'b0;
        v_pop     = 1'b0;
        v_kind    = bsc_pkg::KIND_LIST;
        v_top_we  = 1'b0;
        v_top_val = i_top;
        v_acc     = ({4'd0, r_rem} << 3) + ({4'd0, r_rem} << 1)
                  + bsc_pkg::ACC_W'(i_data_byte[3:0]);
        v_dec     = (r_rem != '0) ? r_rem - 1'b1 : r_rem;

        if (r_count >= bsc_pkg::POS_LIMIT) begin
            v_none = 1'b0;
            v_st   = bsc_pkg::ST_LIMIT;
        end else begin
            case (r_phase)
                bsc_pkg::PH_EXPECT: begin
                    if (i_data_byte == bsc_pkg::CH_E) begin
                        if (r_level == '0 || i_top == bsc_pkg::KIND_DVAL) begin
                            v_none = 1'b0;
                            v_st   = bsc_pkg::ST_MALFORMED;
                        end else begin
                            v_pop  = 1'b1;
                            v_done = 1'b1;
                        end
                    end else if (r_level != '0 && i_top == bsc_pkg::KIND_DKEY
                                 && !bsc_pkg::is_digit(i_data_byte)) begin
                        v_none = 1'b0;
                        v_st   = bsc_pkg::ST_MALFORMED;
                    end else if (i_data_byte == bsc_pkg::CH_I) begin
                        p_phase = bsc_pkg::PH_INT_START;
                    end else if (i_data_byte == bsc_pkg::CH_L
                                 || i_data_byte == bsc_pkg::CH_D) begin
                        if (r_level >= bsc_pkg::DEPTH_W'(bsc_pkg::MAX_DEPTH)) begin
                            v_none = 1'b0;
                            v_st   = bsc_pkg::ST_LIMIT;
                        end else begin
                            v_push = 1'b1;
                            v_kind = (i_data_byte == bsc_pkg::CH_L) ?
                                     bsc_pkg::KIND_LIST : bsc_pkg::KIND_DKEY;
                        end
                    end else if (bsc_pkg::is_digit(i_data_byte)) begin
                        p_rem   = bsc_pkg::POS_BITS'(i_data_byte[3:0]);
                        p_phase = bsc_pkg::PH_STR_LEN;
                    end else begin
                        v_none = 1'b0;
                        v_st   = bsc_pkg::ST_MALFORMED;
                    end
                end
                bsc_pkg::PH_INT_START: begin
                    if (i_data_byte == bsc_pkg::CH_MINUS) begin
                        p_phase = bsc_pkg::PH_INT_NEG;
                    end else if (i_data_byte == bsc_pkg::CH_ZERO) begin
                        p_phase = bsc_pkg::PH_INT_ZERO;
                    end else if (bsc_pkg::is_digit(i_data_byte)) begin
                        p_phase = bsc_pkg::PH_INT_DIGITS;
                    end else begin
                        v_none = 1'b0;
                        v_st   = bsc_pkg::ST_MALFORMED;
                    end
                end
                bsc_pkg::PH_INT_NEG: begin
                    if (bsc_pkg::is_digit(i_data_byte)
                        && i_data_byte != bsc_pkg::CH_ZERO) begin
                        p_phase = bsc_pkg::PH_INT_DIGITS;
                    end else begin
                        v_none = 1'b0;
                        v_st   = bsc_pkg::ST_MALFORMED;
                    end
                end
                bsc_pkg::PH_INT_ZERO: begin
                    if (i_data_byte == bsc_pkg::CH_E) begin
                        v_done = 1'b1;
                    end else begin
                        v_none = 1'b0;
                        v_st   = bsc_pkg::ST_MALFORMED;
                    end
                end
                bsc_pkg::PH_INT_DIGITS: begin
                    if (i_data_byte == bsc_pkg::CH_E) begin
                        v_done = 1'b1;
                    end else if (!bsc_pkg::is_digit(i_data_byte)) begin
                        v_none = 1'b0;
                        v_st   = bsc_pkg::ST_MALFORMED;
                    end
                end
                bsc_pkg::PH_STR_LEN: begin
                    if (bsc_pkg::is_digit(i_data_byte)) begin
                        // saturating length accumulate
                        p_rem = (v_acc > bsc_pkg::ACC_W'(bsc_pkg::POS_LIMIT)) ?
                                bsc_pkg::POS_LIMIT : v_acc[bsc_pkg::POS_BITS-1:0];
                    end else if (i_data_byte == bsc_pkg::CH_COLON) begin
                        if (r_rem == '0) begin
                            v_done = 1'b1;
                        end else begin
                            p_phase = bsc_pkg::PH_STR_BODY;
                        end
                    end else begin
                        v_none = 1'b0;
                        v_st   = bsc_pkg::ST_MALFORMED;
                    end
                end
                bsc_pkg::PH_STR_BODY: begin
                    p_rem = v_dec;
                    if (v_dec == '0) begin
                        v_done = 1'b1;
                    end
                end
                default: begin
                    v_none = 1'b0;
                    v_st   = bsc_pkg::ST_MALFORMED;
                end
            endcase
        end

        if (v_push) begin
            p_level   = r_level + 1'b1;
            p_phase   = bsc_pkg::PH_EXPECT;
            v_top_we  = 1'b1;
            v_top_val = v_kind;
        end
        if (v_pop) begin
            p_level   = r_level - 1'b1;
            v_top_we  = 1'b1;
            v_top_val = i_below;
        end
        // finished value: top level ends the check, else flip dict slot
        v_base = v_pop ? i_below : i_top;
        if (v_done) begin
            if (p_level == '0) begin
                v_none = 1'b0;
                v_st   = bsc_pkg::ST_VALID;
            end else begin
                v_top_we  = 1'b1;
                v_top_val = bsc_pkg::flip_kind(v_base);
                p_phase   = bsc_pkg::PH_EXPECT;
            end
        end
        if (v_none && i_last_byte) begin
            v_none = 1'b0;
            v_st   = bsc_pkg::ST_INCOMPLETE;
        end
    end

    assign v_apply = i_fire && !r_given && v_none;

    always_comb begin
        n_phase = r_phase;
        n_level = r_level;
        n_rem   = r_rem;
        n_count = r_count;
        n_given = r_given;
        if (i_fire) begin
            if (i_last_byte) begin
                n_phase = bsc_pkg::PH_EXPECT;
                n_level = '0;
                n_rem   = '0;
                n_count = '0;
                n_given = 1'b0;
            end else if (!r_given) begin
                if (v_none) begin
                    n_phase = p_phase;
                    n_level = p_level;
                    n_rem   = p_rem;
                    n_count = r_count + 1'b1;
                end else begin
                    n_given = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bsc_pkg::PH_EXPECT;
            r_level <= '0;
            r_rem   <= '0;
            r_count <= '0;
            r_given <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_level <= n_level;
            r_rem   <= n_rem;
            r_count <= n_count;
            r_given <= n_given;
        end
    end

    // stack keeps the entry under the new top in its read register
    assign v_rd = n_level - bsc_pkg::DEPTH_W'(2);

    always_comb begin
        o_cmd.wr_en   = v_apply && v_push && (r_level != '0);
        o_cmd.wr_addr = bsc_pkg::ADDR_W'(r_level - 1'b1);
        o_cmd.rd_addr = v_rd[bsc_pkg::ADDR_W-1:0];
        o_cmd.top_we  = v_apply && v_top_we;
        o_cmd.top_val = v_top_val;
    end

    always_comb begin
        o_res.valid    = i_fire && !r_given && !v_none;
        o_res.status   = v_st;
        o_res.position = (v_st == bsc_pkg::ST_VALID || v_st == bsc_pkg::ST_INCOMPLETE) ?
                         r_count + 1'b1 : r_count;
    end

    assign o_stat.level = r_level;
    assign o_stat.given = r_given;

endmodule

[rtl/bencode_syntax_checker_unit.sv]
// ----------------------------------------------------------------------------
// bencode_syntax_checker_unit
// Streaming bencode syntax checker: one byte per beat, one verdict per buffer.
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  ---------------------------------------
//  in       i_in_valid / o_in_ready  i_data_byte[7:0], i_last_byte
//  out      o_out_valid / i_out_ready o_status[1:0], o_position[15:0]
//
//  One byte per clock while no verdict waits; the verdict appears in the cycle
//  after the deciding byte. The per-byte loop is a read-modify-write of the
//  nesting stack top, with the entry below it prefetched from the stack RAM.
//  Reset (i_rst_n low, synchronous) returns the parser to "expecting a value";
//  stack RAM contents are not cleared, no clearing pass is needed.
//  o_in_ready is low in reset and while a verdict sits unaccepted in the
//  output register.
//
//  status: 0 valid, 1 incomplete, 2 malformed, 3 depth/position limit.
//  After a verdict the rest of the buffer (through the last_byte beat) is
//  consumed silently.
// ----------------------------------------------------------------------------
module bencode_syntax_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_position
);

    logic                 w_fire;
    bsc_pkg::t_stack_cmd  w_cmd;
    bsc_pkg::t_kind       w_top;
    bsc_pkg::t_kind       w_below;
    bsc_pkg::t_result     w_res;
    bsc_pkg::t_ctrl_stat  w_stat;

    logic                 r_out_valid;
    bsc_pkg::t_status     r_status;
    logic [15:0]          r_position;

    // output register frees up in the same cycle it is taken
    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_fire     = i_in_valid && o_in_ready;

    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_top       (w_top),
        .i_below     (w_below),
        .o_cmd       (w_cmd),
        .o_res       (w_res),
        .o_stat      (w_stat)
    );

    bsc_stack u_stack (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .o_top   (w_top),
        .o_below (w_below)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_status   <= w_res.status;
            r_position <= w_res.position[15:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;

    // nesting never passes the stack depth
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.level <= bsc_pkg::DEPTH_W'(bsc_pkg::MAX_DEPTH))
        else $error("stack level above depth limit");

    // a last beat always leaves the parser clean
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_last_byte) |=> (w_stat.level == '0 && !w_stat.given))
        else $error("parser not cleared after last beat");

    // once a verdict is out, the buffer tail yields nothing
    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_stat.given) |-> !w_res.valid)
        else $error("second verdict for one buffer");

    // a valid value has at least one byte
    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res.status == bsc_pkg::ST_VALID) |-> (w_res.position != '0))
        else $error("valid verdict with zero length");

endmodule
